// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define SRC_ASSERT_CR(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on clk_i and rst_ni.
`define SRC_ASSERT(lbl, prop, msg) `SRC_ASSERT_CR(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/src_pkg.sv =====
// Constants and shared types of the separable row convolution block.
package src_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 16;
  localparam int TAP_IDX_W  = 7;
  localparam int RADIUS_W   = 6;
  localparam int FRAC_BITS  = 15;

  localparam int MAX_TAPS   = 71;
  localparam int MAX_COLS   = 4096;
  localparam int MAX_RADIUS = (MAX_TAPS - 1) / 2;

  localparam int RAD_W      = (MAX_RADIUS > 1) ? $clog2(MAX_RADIUS + 1) : 1;
  localparam int CNT_W      = $clog2(MAX_COLS + 1);
  localparam int CELL_IW    = $clog2(MAX_TAPS);
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int ACC_W      = PROD_W + $clog2(MAX_TAPS);

  typedef struct packed {
    logic shift;
    logic rotate;
  } src_cell_ctrl_t;

  typedef struct packed {
    logic clear;
    logic mul_en;
  } src_mac_ctrl_t;

endpackage

// ===== rtl/src_cell.sv =====
// One cell of the window ring: a sample and a tap, shifted or rotated to neighbors.
module src_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  src_pkg::src_cell_ctrl_t             ctrl_i,
  input  logic signed [src_pkg::SAMPLE_W-1:0] shift_w_i,
  input  logic signed [src_pkg::SAMPLE_W-1:0] rot_w_i,
  input  logic signed [src_pkg::COEF_W-1:0]   rot_t_i,
  input  logic                                tap_we_i,
  input  logic signed [src_pkg::COEF_W-1:0]   tap_i,
  output logic signed [src_pkg::SAMPLE_W-1:0] w_o,
  output logic signed [src_pkg::COEF_W-1:0]   t_o
);
  import src_pkg::*;

  logic signed [SAMPLE_W-1:0] w_q, w_d;
  logic signed [COEF_W-1:0]   t_q, t_d;

  always_comb begin
    w_d = w_q;
    t_d = t_q;
    priority if (ctrl_i.rotate) begin
      w_d = rot_w_i;
      t_d = rot_t_i;
    end else if (ctrl_i.shift) begin
      w_d = shift_w_i;
    end else if (tap_we_i) begin
      t_d = tap_i;
    end else begin
      w_d = w_q;
      t_d = t_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= '0;
      t_q <= '0;
    end else begin
      w_q <= w_d;
      t_q <= t_d;
    end
  end

  assign w_o = w_q;
  assign t_o = t_q;

endmodule

// ===== rtl/src_mac.sv =====
// Multiply-accumulate unit at the head of the ring, with rounding and saturation.
module src_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  src_pkg::src_mac_ctrl_t              ctrl_i,
  input  logic signed [src_pkg::SAMPLE_W-1:0] w_i,
  input  logic signed [src_pkg::COEF_W-1:0]   t_i,
  output logic signed [src_pkg::SAMPLE_W-1:0] value_o
);
  import src_pkg::*;

  localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((2 ** (SAMPLE_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -(ACC_W'(2 ** (SAMPLE_W - 1)));

  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_v_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [ACC_W-1:0]  shifted;

  always_ff @(posedge clk_i) begin
    prod_q <= w_i * t_i;
  end

  always_comb begin
    acc_d = acc_q;
    priority if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (prod_v_q) begin
      acc_d = acc_q + ACC_W'(prod_q);
    end else begin
      acc_d = acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
      acc_q    <= '0;
    end else begin
      prod_v_q <= ctrl_i.mul_en;
      acc_q    <= acc_d;
    end
  end

  assign rnd     = acc_q + HALF;
  assign shifted = rnd >>> FRAC_BITS;

  always_comb begin
    priority if (shifted > SAT_MAX) begin
      value_o = SAT_MAX[SAMPLE_W-1:0];
    end else if (shifted < SAT_MIN) begin
      value_o = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      value_o = shifted[SAMPLE_W-1:0];
    end
  end

endmodule

// ===== rtl/separable_row_convolution.sv =====
// Top level of the separable row convolution block.
// One result per line position: positions within radius of either line end give value 0
// with is_border set, the others the rounded, saturated convolution of 2*radius+1 samples.
// The window and taps sit in a ring of cells that rotates once past a single multiplier for each
// filtered result. On the sample marked last_in_line the trailing border results follow it. The
// input is stalled until the results of a sample have been pushed; a stalled output holds them.
// Radius writes take effect at the start of the next line.
module separable_row_convolution (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [src_pkg::RADIUS_W-1:0]          cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  cmd_i,
  input  logic signed [src_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic                                  last_in_line_i,
  input  logic [src_pkg::TAP_IDX_W-1:0]         tap_index_i,
  input  logic signed [src_pkg::COEF_W-1:0]     coefficient_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [src_pkg::SAMPLE_W-1:0]   value_o,
  output logic                                  is_border_o,
  output logic                                  line_end_o,
  output logic                                  run_last_o,
  output logic                                  too_long_o
);
  import src_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SUM   = 5'b00010,
    S_ACC   = 5'b00100,
    S_MAIN  = 5'b01000,
    S_FLUSH = 5'b10000
  } src_state_e;

  src_state_e state_q, state_d;

  logic [RADIUS_W-1:0] radius_q;
  logic [RAD_W-1:0]    line_r_q, line_r_d;
  logic [CNT_W-1:0]    pos_q, pos_d;
  logic [CNT_W-1:0]    emit_q, emit_d;
  logic                ovf_q, ovf_d;
  logic [CELL_IW-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]    fl_q, fl_d;
  logic [CNT_W-1:0]    fl_n_q, fl_n_d;
  logic                fl_ovf_q, fl_ovf_d;
  logic                job_flush_q, job_flush_d;
  logic                main_sum_q, main_sum_d;

  logic                out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] value_q, value_d;
  logic                border_q, border_d;
  logic                line_end_q, line_end_d;
  logic                run_last_q, run_last_d;
  logic                too_long_q, too_long_d;

  logic                accept, acc_sample, acc_tap, tap_wr;
  logic [RAD_W-1:0]    eff_r, r_new;
  logic [CNT_W-1:0]    r_ext, qpos, pos_n, emit_n;
  logic                take, has_main, is_sum, ovf_n, flush_any;
  logic                out_free, push, fl_last;

  src_cell_ctrl_t      cell_ctrl;
  src_mac_ctrl_t       mac_ctrl;
  logic signed [SAMPLE_W-1:0] mac_value;

  logic signed [SAMPLE_W-1:0] w_arr [MAX_TAPS];
  logic signed [COEF_W-1:0]   t_arr [MAX_TAPS];

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign acc_sample = accept && !cmd_i;
  assign acc_tap    = accept && cmd_i;
  assign tap_wr     = acc_tap && (tap_index_i < TAP_IDX_W'(MAX_TAPS));

  assign eff_r    = (radius_q > RADIUS_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS)
                                                       : RAD_W'(radius_q);
  assign r_new    = (pos_q == '0) ? eff_r : line_r_q;
  assign r_ext    = CNT_W'(r_new);
  assign take     = !ovf_q && (pos_q < CNT_W'(MAX_COLS));
  assign has_main = take && (pos_q >= r_ext);
  assign qpos     = pos_q - r_ext;
  assign is_sum   = qpos >= r_ext;
  assign pos_n    = take ? pos_q + CNT_W'(1) : pos_q;
  assign emit_n   = has_main ? qpos + CNT_W'(1) : emit_q;
  assign ovf_n    = ovf_q || !take;
  assign flush_any = last_in_line_i && (emit_n < pos_n);

  assign out_free = !out_valid_q || !out_stall_i;
  assign fl_last  = (fl_q + CNT_W'(1)) == fl_n_q;

  assign cell_ctrl.shift  = acc_sample && take;
  assign cell_ctrl.rotate = (state_q == S_SUM);
  assign mac_ctrl.clear   = accept;
  assign mac_ctrl.mul_en  = (state_q == S_SUM) && (cnt_q <= (CELL_IW'(line_r_q) << 1));

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    localparam int NXT = (k + 1) % MAX_TAPS;
    logic signed [SAMPLE_W-1:0] shift_w;
    if (k == 0) begin : g_head
      assign shift_w = sample_i;
    end else begin : g_body
      assign shift_w = w_arr[k-1];
    end
    src_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (cell_ctrl),
      .shift_w_i (shift_w),
      .rot_w_i   (w_arr[NXT]),
      .rot_t_i   (t_arr[NXT]),
      .tap_we_i  (tap_wr && (tap_index_i == TAP_IDX_W'(k))),
      .tap_i     (coefficient_i),
      .w_o       (w_arr[k]),
      .t_o       (t_arr[k])
    );
  end

  src_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .w_i     (w_arr[0]),
    .t_i     (t_arr[0]),
    .value_o (mac_value)
  );

  always_comb begin
    state_d     = state_q;
    line_r_d    = line_r_q;
    pos_d       = pos_q;
    emit_d      = emit_q;
    ovf_d       = ovf_q;
    cnt_d       = cnt_q;
    fl_d        = fl_q;
    fl_n_d      = fl_n_q;
    fl_ovf_d    = fl_ovf_q;
    job_flush_d = job_flush_q;
    main_sum_d  = main_sum_q;
    push        = 1'b0;
    value_d     = value_q;
    border_d    = border_q;
    line_end_d  = line_end_q;
    run_last_d  = run_last_q;
    too_long_d  = too_long_q;

    unique case (state_q)
      S_IDLE: begin
        if (acc_sample) begin
          if (take) begin
            line_r_d = r_new;
          end
          if (last_in_line_i) begin
            pos_d  = '0;
            emit_d = '0;
            ovf_d  = 1'b0;
          end else begin
            pos_d  = pos_n;
            emit_d = emit_n;
            ovf_d  = ovf_n;
          end
          fl_d        = emit_n;
          fl_n_d      = pos_n;
          fl_ovf_d    = ovf_n;
          job_flush_d = flush_any;
          main_sum_d  = is_sum;
          cnt_d       = '0;
          priority if (has_main && is_sum) begin
            state_d = S_SUM;
          end else if (has_main) begin
            state_d = S_MAIN;
          end else if (flush_any) begin
            state_d = S_FLUSH;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_SUM: begin
        cnt_d = cnt_q + CELL_IW'(1);
        if (cnt_q == CELL_IW'(MAX_TAPS - 1)) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        state_d = S_MAIN;
      end
      S_MAIN: begin
        if (out_free) begin
          push       = 1'b1;
          value_d    = main_sum_q ? mac_value : '0;
          border_d   = !main_sum_q;
          line_end_d = 1'b0;
          run_last_d = !job_flush_q;
          too_long_d = 1'b0;
          state_d    = job_flush_q ? S_FLUSH : S_IDLE;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          push       = 1'b1;
          value_d    = '0;
          border_d   = 1'b1;
          line_end_d = fl_last;
          run_last_d = fl_last;
          too_long_d = fl_ovf_q;
          fl_d       = fl_q + CNT_W'(1);
          if (fl_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (push) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      radius_q    <= '0;
      line_r_q    <= '0;
      pos_q       <= '0;
      emit_q      <= '0;
      ovf_q       <= 1'b0;
      cnt_q       <= '0;
      fl_q        <= '0;
      fl_n_q      <= '0;
      fl_ovf_q    <= 1'b0;
      job_flush_q <= 1'b0;
      main_sum_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        radius_q <= cfg_data_i;
      end
      line_r_q    <= line_r_d;
      pos_q       <= pos_d;
      emit_q      <= emit_d;
      ovf_q       <= ovf_d;
      cnt_q       <= cnt_d;
      fl_q        <= fl_d;
      fl_n_q      <= fl_n_d;
      fl_ovf_q    <= fl_ovf_d;
      job_flush_q <= job_flush_d;
      main_sum_q  <= main_sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q    <= value_d;
    border_q   <= border_d;
    line_end_q <= line_end_d;
    run_last_q <= run_last_d;
    too_long_q <= too_long_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign is_border_o = border_q;
  assign line_end_o  = line_end_q;
  assign run_last_o  = run_last_q;
  assign too_long_o  = too_long_q;

endmodule

// ===== rtl/src_checker.sv =====
// Port-level checker for the separable row convolution block, bound to the top level.
`include "assert_macros.svh"

module src_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                cfg_we_i,
  input logic [src_pkg::RADIUS_W-1:0]        cfg_data_i,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                cmd_i,
  input logic signed [src_pkg::SAMPLE_W-1:0] sample_i,
  input logic                                last_in_line_i,
  input logic [src_pkg::TAP_IDX_W-1:0]       tap_index_i,
  input logic signed [src_pkg::COEF_W-1:0]   coefficient_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [src_pkg::SAMPLE_W-1:0] value_o,
  input logic                                is_border_o,
  input logic                                line_end_o,
  input logic                                run_last_o,
  input logic                                too_long_o
);
  import src_pkg::*;

  `SRC_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "stalled transfer dropped")
  `SRC_ASSERT(a_border_zero, out_valid_o && is_border_o |-> value_o == '0, "border value not zero")
  `SRC_ASSERT(a_end_last, out_valid_o && line_end_o |-> run_last_o && is_border_o, "bad line end")
  `SRC_ASSERT(a_long_border, out_valid_o && too_long_o |-> is_border_o, "too_long off border")

endmodule

bind separable_row_convolution src_checker u_src_checker (.*);
